[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/vpsd_pkg.sv]
`default_nettype none

package vpsd_pkg;

   localparam int ROW_W = 32;
   localparam int LEN_W = 63;
   localparam int DEFAULT_MAX_PREFIX_BYTES = 10;
   localparam int LEB_GROUP_BITS = 7;
   localparam int LEB_CONT_BIT = 7;
   localparam int SHIFT_W = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_BODY      = 3'd0;
   localparam logic [2:0] ST_LENGTH    = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_DONE      = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;

   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_START_OFFSET = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [7:0]       body_byte;
      logic             string_end;
      logic [ROW_W-1:0] row_index;
      logic [LEN_W-1:0] string_length;
      logic [LEN_W-1:0] available_bytes;
      logic [LEN_W-1:0] end_position;
      logic             last;
   } rsp_type;

   // results produced by one request, first in r0
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

`default_nettype wire

[rtl/varuint_prefixed_string_deframer.sv]
// a request's results are written into the result queue registers and shown on rsp from there, behind older results
// throughput: one request per cycle while the result queue has room, set by the single-pass state update in the core
// a request that finishes the last row gives two results; the four-entry result queue
// takes requests while it holds at most two results
// reset (synchronous): rows, position, prefix state and registers clear, queue empties
`default_nettype none
`include "assert_macros.svh"

module varuint_prefixed_string_deframer #(
   parameter int MAX_PREFIX_BYTES = vpsd_pkg::DEFAULT_MAX_PREFIX_BYTES
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire vpsd_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output vpsd_pkg::rsp_type        rsp_data,
   input  wire logic                csr_write,
   input  wire logic                csr_index,
   input  wire logic [31:0]         csr_data
);
   import vpsd_pkg::*;

   push_type           push;
   logic [LEVEL_W-1:0] level;
   logic               req_accept;
   logic               rsp_final;

   assign req_ready  = level <= LEVEL_W'(QUEUE_DEPTH - 2);
   assign req_accept = req_valid && req_ready;

   // a halting result leaves the block with nothing more to send
   assign rsp_final = rsp_valid && rsp_ready &&
                      (rsp_data.status == ST_DONE || rsp_data.status == ST_UNDERFLOW ||
                       rsp_data.status == ST_TOO_LONG);

   vpsd_core #(
      .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push)
   );

   vpsd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .level     (level)
   );

   `ASSERT_IMPLIES(a_room, push.count == 2'd2, level <= LEVEL_W'(QUEUE_DEPTH - 2))
   `ASSERT_IMPLIES(a_pair, rsp_valid && !rsp_data.last, level >= LEVEL_W'(2))
   `ASSERT_NEXT(a_halt, rsp_final, !rsp_valid)

endmodule

`default_nettype wire

[rtl/vpsd_core.sv]
`default_nettype none

module vpsd_core #(
   parameter int MAX_PREFIX_BYTES = vpsd_pkg::DEFAULT_MAX_PREFIX_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_accept,
   input  wire vpsd_pkg::req_type     req_data,
   input  wire logic                  csr_write,
   input  wire logic                  csr_index,
   input  wire logic [31:0]           csr_data,
   output vpsd_pkg::push_type         push
);
   import vpsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_PREFIX_BYTES + 1);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_PREFIX = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;
   localparam logic [1:0] PH_HALT   = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] recv_ff, recv_in;
   logic [ROW_W-1:0] rows_ff, rows_in;
   logic [LEN_W-1:0] consumed_ff, consumed_in;
   logic [31:0]      row_count_ff;
   logic [31:0]      start_offset_ff;

   logic [ROW_W-1:0] rows_next;
   logic             rows_left;
   logic             done_after;
   logic             consume;
   logic [LEN_W-1:0] end_pos;
   logic [CNT_W-1:0] cnt_base;
   logic [LEN_W-1:0] acc_base;
   logic [LEN_W-1:0] acc_new;
   logic [CNT_W-1:0] cnt_new;
   logic [SHIFT_W-1:0] shift;

   function automatic rsp_type make_rsp(logic [2:0] st, logic [7:0] b, logic e,
                                        logic [ROW_W-1:0] row, logic [LEN_W-1:0] len,
                                        logic [LEN_W-1:0] avail,
                                        logic [LEN_W-1:0] endp);
      rsp_type r;
      r.status          = st;
      r.body_byte       = b;
      r.string_end      = e;
      r.row_index       = row;
      r.string_length   = len;
      r.available_bytes = avail;
      r.end_position    = endp;
      r.last            = 1'b0;
      return r;
   endfunction

   assign rows_next  = rows_ff + ROW_W'(1);
   assign rows_left  = rows_ff < row_count_ff;
   assign done_after = rows_next >= row_count_ff;
   assign consume    = !(phase_ff == PH_IDLE && !rows_left) && !req_data.command;
   assign end_pos    = LEN_W'(start_offset_ff) + consumed_ff + LEN_W'(consume);

   assign cnt_base = (phase_ff == PH_IDLE) ? '0 : pcnt_ff;
   assign acc_base = (phase_ff == PH_IDLE) ? '0 : acc_ff;
   assign shift    = SHIFT_W'(int'(cnt_base) * LEB_GROUP_BITS);
   assign acc_new  = acc_base | (LEN_W'(req_data.data_byte[LEB_GROUP_BITS-1:0]) << shift);
   assign cnt_new  = cnt_base + CNT_W'(1);

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      pcnt_in     = pcnt_ff;
      remain_in   = remain_ff;
      recv_in     = recv_ff;
      rows_in     = rows_ff;
      consumed_in = consumed_ff;
      push        = '0;
      if (req_accept && phase_ff != PH_HALT) begin
         if (phase_ff == PH_IDLE && !rows_left) begin
            push.r0    = make_rsp(ST_DONE, '0, 1'b0, rows_ff, '0, '0, end_pos);
            push.count = 2'd1;
            phase_in   = PH_HALT;
         end else if (req_data.command) begin
            if (phase_ff == PH_BODY) begin
               push.r0 = make_rsp(ST_UNDERFLOW, '0, 1'b0, rows_ff, acc_ff, recv_ff, '0);
            end else begin
               push.r0 = make_rsp(ST_UNDERFLOW, '0, 1'b0, rows_ff, LEN_W'(1), '0, '0);
            end
            push.count = 2'd1;
            phase_in   = PH_HALT;
         end else begin
            consumed_in = consumed_ff + LEN_W'(1);
            if (phase_ff == PH_BODY) begin
               recv_in   = recv_ff + LEN_W'(1);
               remain_in = remain_ff - LEN_W'(1);
               push.r0   = make_rsp(ST_BODY, req_data.data_byte, remain_ff == LEN_W'(1),
                                    rows_ff, '0, '0, '0);
               push.count = 2'd1;
            end else begin
               acc_in  = acc_new;
               pcnt_in = cnt_new;
               if (!req_data.data_byte[LEB_CONT_BIT]) begin
                  push.count = 2'd1;
                  if (acc_new == '0) begin
                     push.r0 = make_rsp(ST_EMPTY, '0, 1'b0, rows_ff, '0, '0, '0);
                  end else begin
                     push.r0   = make_rsp(ST_LENGTH, '0, 1'b0, rows_ff, acc_new, '0, '0);
                     phase_in  = PH_BODY;
                     remain_in = acc_new;
                     recv_in   = '0;
                  end
               end else if (int'(cnt_new) >= MAX_PREFIX_BYTES) begin
                  push.r0    = make_rsp(ST_TOO_LONG, '0, 1'b0, rows_ff, '0, '0, '0);
                  push.count = 2'd1;
                  phase_in   = PH_HALT;
               end else begin
                  phase_in = PH_PREFIX;
               end
            end
            // row finished: body end or empty string
            if ((phase_ff == PH_BODY && remain_ff == LEN_W'(1)) ||
                (phase_ff != PH_BODY && !req_data.data_byte[LEB_CONT_BIT] &&
                 acc_new == '0)) begin
               rows_in   = rows_next;
               phase_in  = PH_IDLE;
               acc_in    = '0;
               pcnt_in   = '0;
               remain_in = '0;
               recv_in   = '0;
               if (done_after) begin
                  push.r1    = make_rsp(ST_DONE, '0, 1'b0, rows_next, '0, '0, end_pos);
                  push.count = 2'd2;
                  phase_in   = PH_HALT;
               end
            end
         end
         if (push.count == 2'd2) begin
            push.r1.last = 1'b1;
         end else begin
            push.r0.last = push.count == 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         acc_ff          <= '0;
         pcnt_ff         <= '0;
         remain_ff       <= '0;
         recv_ff         <= '0;
         rows_ff         <= '0;
         consumed_ff     <= '0;
         row_count_ff    <= '0;
         start_offset_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         acc_ff      <= acc_in;
         pcnt_ff     <= pcnt_in;
         remain_ff   <= remain_in;
         recv_ff     <= recv_in;
         rows_ff     <= rows_in;
         consumed_ff <= consumed_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_ROW_COUNT:    row_count_ff    <= csr_data;
               CSR_START_OFFSET: start_offset_ff <= csr_data;
               default:          row_count_ff    <= row_count_ff;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

[rtl/vpsd_rsp_queue.sv]
`default_nettype none

module vpsd_rsp_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire vpsd_pkg::push_type           push,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output vpsd_pkg::rsp_type                 rsp_data,
   output logic [vpsd_pkg::LEVEL_W-1:0]      level
);
   import vpsd_pkg::*;

   rsp_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               pop;

   assign rsp_valid = level_ff != '0;
   assign rsp_data  = mem_ff[rp_ff];
   assign level     = level_ff;
   assign pop       = rsp_valid && rsp_ready;

   assign wp_in    = wp_ff + PTR_W'(push.count);
   assign rp_in    = rp_ff + PTR_W'(pop);
   assign level_in = level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_ff + PTR_W'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         level_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire
